// File: sv/ibsd_pkg.sv
// shared types and constants of the pixel binning block sum
`default_nettype none

package ibsd_pkg;

  // data widths
  localparam int unsigned PIX_W     = 32;
  localparam int unsigned SUM_W     = 48;
  localparam int unsigned COL_OUT_W = 12;
  localparam int unsigned ROW_W     = 16;
  localparam int unsigned DIM_W     = 16;
  localparam int unsigned FACT_W    = 9;
  localparam int unsigned DWID_W    = 13;
  localparam int unsigned SUB_W     = 8;

  // default accumulator row length and front-to-back queue depth
  localparam int unsigned DEF_MAX_DEST_WIDTH = 4096;
  localparam int unsigned QUEUE_DEPTH        = 4;

  // configuration port
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  // saturation limits of a sum
  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // largest block factor
  localparam logic [FACT_W-1:0] FACT_MAX = 9'd256;

  // register indexes
  typedef enum logic [2:0] {
    REG_SRC_WIDTH   = 3'd0,
    REG_SRC_HEIGHT  = 3'd1,
    REG_FACTOR_X    = 3'd2,
    REG_FACTOR_Y    = 3'd3,
    REG_DEST_WIDTH  = 3'd4,
    REG_DEST_HEIGHT = 3'd5
  } ibsd_reg_e;

  // configuration registers
  typedef struct packed {
    logic [DIM_W-1:0]  src_width;
    logic [DIM_W-1:0]  src_height;
    logic [FACT_W-1:0] factor_x;
    logic [FACT_W-1:0] factor_y;
    logic [DWID_W-1:0] dest_width;
    logic [DIM_W-1:0]  dest_height;
  } ibsd_cfg_t;

  localparam ibsd_cfg_t CFG_RESET = '{
    src_width:   16'd1,
    src_height:  16'd1,
    factor_x:    9'd2,
    factor_y:    9'd2,
    dest_width:  13'd1,
    dest_height: 16'd1
  };

  // classification of one item from the front to the back
  typedef struct packed {
    logic emit;   // last pixel of its block
    logic first;  // first pixel of its block, accumulator starts from zero
    logic done;   // last block of the image
  } ibsd_flags_t;

endpackage

`default_nettype wire

// File: sv/ibsd_pix_if.sv
// source pixel channel
`default_nettype none

interface ibsd_pix_if
  import ibsd_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

`default_nettype wire

// File: sv/ibsd_sum_if.sv
// block sum result channel
`default_nettype none

interface ibsd_sum_if
  import ibsd_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic signed [SUM_W-1:0]     block_sum;
  logic        [COL_OUT_W-1:0] dest_col;
  logic        [ROW_W-1:0]     dest_row;
  logic                        image_done;

  modport source (output valid, output block_sum, output dest_col, output dest_row,
                  output image_done, input ready);
  modport sink   (input valid, input block_sum, input dest_col, input dest_row,
                  input image_done, output ready);
endinterface

`default_nettype wire

// File: sv/ibsd_ram.sv
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module ibsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output      logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/ibsd_front.sv
// front end: raster counters, block classification and drop of outside pixels
`default_nettype none

module ibsd_front
  import ibsd_pkg::*;
#(
  parameter int unsigned MAX_DEST_WIDTH = DEF_MAX_DEST_WIDTH,
  parameter int unsigned QW = 8,
  localparam int unsigned AW = (MAX_DEST_WIDTH > 1) ? $clog2(MAX_DEST_WIDTH) : 1
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire ibsd_cfg_t  cfg_i,
  input  wire logic       restart_i,
  ibsd_pix_if.sink        pix,
  input  wire logic       q_full_i,
  output      logic       q_push_o,
  output      logic [QW-1:0] q_data_o
);

  localparam logic [DIM_W:0] MAX_DW = (DIM_W+1)'(MAX_DEST_WIDTH);

  logic [DIM_W-1:0] scol_q, scol_d, srow_q, srow_d;
  logic [SUB_W-1:0] subc_q, subc_d, subr_q, subr_d;
  logic [DIM_W-1:0] bcol_q, bcol_d, brow_q, brow_d;

  logic [DIM_W-1:0]  sw, sh, dh;
  logic [DIM_W:0]    dw;
  logic [FACT_W-1:0] fx, fy;
  logic              scol_last, srow_last, subc_last, subr_last;
  logic              col_last, row_last, in_dest, accept;
  ibsd_flags_t       flags;

  // effective configuration
  always_comb begin
    sw = (cfg_i.src_width == '0) ? DIM_W'(1) : cfg_i.src_width;
    sh = (cfg_i.src_height == '0) ? DIM_W'(1) : cfg_i.src_height;
    dh = (cfg_i.dest_height == '0) ? DIM_W'(1) : cfg_i.dest_height;
    dw = (cfg_i.dest_width == '0) ? (DIM_W+1)'(1) : (DIM_W+1)'(cfg_i.dest_width);
    if (dw > MAX_DW) begin
      dw = MAX_DW;
    end
    fx = (cfg_i.factor_x == '0) ? FACT_W'(1) :
         (cfg_i.factor_x > FACT_MAX) ? FACT_MAX : cfg_i.factor_x;
    fy = (cfg_i.factor_y == '0) ? FACT_W'(1) :
         (cfg_i.factor_y > FACT_MAX) ? FACT_MAX : cfg_i.factor_y;
  end

  // position tests
  always_comb begin
    scol_last = ({1'b0, scol_q} + 17'd1) >= {1'b0, sw};
    srow_last = ({1'b0, srow_q} + 17'd1) >= {1'b0, sh};
    subc_last = ({1'b0, subc_q} + 9'd1) >= fx;
    subr_last = ({1'b0, subr_q} + 9'd1) >= fy;
    col_last  = subc_last || scol_last;
    row_last  = subr_last || srow_last;
    in_dest   = ({1'b0, bcol_q} < dw) && (brow_q < dh);
    flags.emit  = col_last && row_last;
    flags.first = (subc_q == '0) && (subr_q == '0);
    flags.done  = (scol_last || (({1'b0, bcol_q} + 17'd1) >= dw)) &&
                  (srow_last || (({1'b0, brow_q} + 17'd1) >= {1'b0, dh}));
  end

  assign pix.ready = !q_full_i;
  assign accept    = pix.valid && pix.ready;
  assign q_push_o  = accept && in_dest;
  assign q_data_o  = {pix.pixel_value, AW'(bcol_q), brow_q, flags};

  // raster advance
  always_comb begin
    scol_d = scol_q;
    srow_d = srow_q;
    subc_d = subc_q;
    subr_d = subr_q;
    bcol_d = bcol_q;
    brow_d = brow_q;
    if (restart_i) begin
      scol_d = '0; srow_d = '0; subc_d = '0; subr_d = '0; bcol_d = '0; brow_d = '0;
    end else if (accept) begin
      if (scol_last) begin
        scol_d = '0;
        subc_d = '0;
        bcol_d = '0;
        if (srow_last) begin
          srow_d = '0;
          subr_d = '0;
          brow_d = '0;
        end else begin
          srow_d = srow_q + DIM_W'(1);
          if (subr_last) begin
            subr_d = '0;
            brow_d = brow_q + DIM_W'(1);
          end else begin
            subr_d = subr_q + SUB_W'(1);
          end
        end
      end else begin
        scol_d = scol_q + DIM_W'(1);
        if (subc_last) begin
          subc_d = '0;
          bcol_d = bcol_q + DIM_W'(1);
        end else begin
          subc_d = subc_q + SUB_W'(1);
        end
      end
    end
  end

  // counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scol_q <= '0; srow_q <= '0; subc_q <= '0; subr_q <= '0; bcol_q <= '0; brow_q <= '0;
    end else begin
      scol_q <= scol_d; srow_q <= srow_d; subc_q <= subc_d;
      subr_q <= subr_d; bcol_q <= bcol_d; brow_q <= brow_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/ibsd_queue.sv
// short fifo between front and back
`default_nettype none

module ibsd_queue
  import ibsd_pkg::*;
#(
  parameter int unsigned QW = 8,
  localparam int unsigned PW = $clog2(QUEUE_DEPTH),
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [QW-1:0] data_i,
  input  wire logic          pop_i,
  output      logic [QW-1:0] data_o,
  output      logic          valid_o,
  output      logic          full_o
);

  logic [QW-1:0] slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] count_q;

  assign data_o  = slot_q[rptr_q];
  assign valid_o = count_q != '0;
  assign full_o  = count_q == CW'(QUEUE_DEPTH);

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + PW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + PW'(1);
      end
      count_q <= count_q + CW'(push_i) - CW'(pop_i);
    end
  end

  // front never pushes into a full queue, back never pops an empty one
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

  // fill level stays within the queue depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("queue fill level out of range");

endmodule

`default_nettype wire

// File: sv/ibsd_back.sv
// back end: accumulator read-modify-write with forwarding, saturation and result register
`default_nettype none

module ibsd_back
  import ibsd_pkg::*;
#(
  parameter int unsigned MAX_DEST_WIDTH = DEF_MAX_DEST_WIDTH,
  parameter int unsigned QW = 8,
  localparam int unsigned AW = (MAX_DEST_WIDTH > 1) ? $clog2(MAX_DEST_WIDTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire logic [QW-1:0] q_data_i,
  output      logic          q_pop_o,
  ibsd_sum_if.source         sum
);

  // item being summed
  logic              b_valid_q;
  logic [PIX_W-1:0]  b_pix_q;
  logic [AW-1:0]     b_col_q;
  logic [ROW_W-1:0]  b_row_q;
  ibsd_flags_t       b_flags_q;

  // head of queue
  logic [PIX_W-1:0]  h_pix;
  logic [AW-1:0]     h_col;
  logic [ROW_W-1:0]  h_row;
  ibsd_flags_t       h_flags;

  // last accumulator write
  logic              lw_valid_q;
  logic [AW-1:0]     lw_col_q;
  logic [SUM_W-1:0]  lw_val_q;

  // result register
  logic              out_valid_q;
  logic [SUM_W-1:0]  out_sum_q;
  logic [AW-1:0]     out_col_q;
  logic [ROW_W-1:0]  out_row_q;
  logic              out_done_q;

  logic [SUM_W-1:0]  rdata, prev, sat, wdata;
  logic [SUM_W:0]    wide;
  logic              b_fire, b_go;

  assign {h_pix, h_col, h_row, h_flags} = q_data_i;

  assign b_fire  = b_valid_q && (!b_flags_q.emit || !out_valid_q || sum.ready);
  assign b_go    = !b_valid_q || b_fire;
  assign q_pop_o = q_valid_i && b_go;

  // accumulator row
  ibsd_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_DEST_WIDTH)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (b_fire),
    .waddr_i (b_col_q),
    .wdata_i (wdata),
    .re_i    (q_pop_o),
    .raddr_i (h_col),
    .rdata_o (rdata)
  );

  // previous partial sum: zero at block start, forwarded when just written
  always_comb begin
    if (b_flags_q.first) begin
      prev = '0;
    end else if (lw_valid_q && (lw_col_q == b_col_q)) begin
      prev = lw_val_q;
    end else begin
      prev = rdata;
    end
  end

  // saturating add
  always_comb begin
    wide = {prev[SUM_W-1], prev} + {{(SUM_W+1-PIX_W){b_pix_q[PIX_W-1]}}, b_pix_q};
    if (wide[SUM_W] != wide[SUM_W-1]) begin
      sat = wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sat = wide[SUM_W-1:0];
    end
    wdata = b_flags_q.emit ? '0 : sat;
  end

  // item stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q  <= 1'b0;
      lw_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        b_valid_q <= 1'b1;
      end else if (b_fire) begin
        b_valid_q <= 1'b0;
      end
      if (b_fire) begin
        lw_valid_q <= 1'b1;
      end
    end
  end

  // item stage payload and forwarding register
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      b_pix_q   <= h_pix;
      b_col_q   <= h_col;
      b_row_q   <= h_row;
      b_flags_q <= h_flags;
    end
    if (b_fire) begin
      lw_col_q <= b_col_q;
      lw_val_q <= wdata;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_fire && b_flags_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (sum.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (b_fire && b_flags_q.emit) begin
      out_sum_q  <= sat;
      out_col_q  <= b_col_q;
      out_row_q  <= b_row_q;
      out_done_q <= b_flags_q.done;
    end
  end

  assign sum.valid      = out_valid_q;
  assign sum.block_sum  = out_sum_q;
  assign sum.dest_col   = COL_OUT_W'(out_col_q);
  assign sum.dest_row   = out_row_q;
  assign sum.image_done = out_done_q;

  // a finished block always lands in the result register
  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_fire && b_flags_q.emit |=> out_valid_q)
    else $error("emitted block not presented");

  // forwarding register tracks the latest accumulator write
  a_fwd_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_fire |=> lw_valid_q && (lw_col_q == $past(b_col_q)))
    else $error("forwarding register out of step");

  // a stalled item keeps its column
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && !b_fire |=> b_valid_q && $stable(b_col_q))
    else $error("stalled item changed");

endmodule

`default_nettype wire

// File: sv/image_block_sum_downsample.sv
// top level of the pixel binning block sum: configuration registers and front/back
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+----------------------------------------------
//  pix_i   | in  | valid/ready      | pixel_value s32
//  sum_o   | out | valid/ready      | block_sum s48, dest_col u12, dest_row u16,
//          |     |                  | image_done
//  apb     | in  | psel/penable     | paddr u5, pwdata/prdata u32, pready tied high
//
// one pixel per cycle while sum_o keeps taking results; the accumulator ram does
// one read and one write per cycle, the latest write forwarded to the next read
// a pixel's block sum enters the result register via the queue and the item stage
// no clearing pass after reset: the first pixel of each block starts from zero
// a four-entry queue between front and back keeps pixels flowing while a result waits
`default_nettype none

module image_block_sum_downsample
  import ibsd_pkg::*;
#(
  parameter int unsigned MAX_DEST_WIDTH = DEF_MAX_DEST_WIDTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  ibsd_pix_if.sink                   pix_i,
  ibsd_sum_if.source                 sum_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output      logic [APB_DATA_W-1:0] prdata,
  output      logic                  pready
);

  localparam int unsigned AW = (MAX_DEST_WIDTH > 1) ? $clog2(MAX_DEST_WIDTH) : 1;
  localparam int unsigned QW = PIX_W + AW + ROW_W + $bits(ibsd_flags_t);

  ibsd_cfg_t     cfg_q;
  ibsd_reg_e     reg_idx;
  logic          wr, restart;
  logic          q_push, q_pop, q_valid, q_full;
  logic [QW-1:0] q_wdata, q_rdata;

  assign pready  = 1'b1;
  assign reg_idx = ibsd_reg_e'(paddr[APB_ADDR_W-1:2]);
  assign wr      = psel && penable && pwrite;
  assign restart = wr && (reg_idx <= REG_DEST_HEIGHT);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (wr) begin
      case (reg_idx)
        REG_SRC_WIDTH:   cfg_q.src_width   <= pwdata[DIM_W-1:0];
        REG_SRC_HEIGHT:  cfg_q.src_height  <= pwdata[DIM_W-1:0];
        REG_FACTOR_X:    cfg_q.factor_x    <= pwdata[FACT_W-1:0];
        REG_FACTOR_Y:    cfg_q.factor_y    <= pwdata[FACT_W-1:0];
        REG_DEST_WIDTH:  cfg_q.dest_width  <= pwdata[DWID_W-1:0];
        REG_DEST_HEIGHT: cfg_q.dest_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      REG_SRC_WIDTH:   prdata = APB_DATA_W'(cfg_q.src_width);
      REG_SRC_HEIGHT:  prdata = APB_DATA_W'(cfg_q.src_height);
      REG_FACTOR_X:    prdata = APB_DATA_W'(cfg_q.factor_x);
      REG_FACTOR_Y:    prdata = APB_DATA_W'(cfg_q.factor_y);
      REG_DEST_WIDTH:  prdata = APB_DATA_W'(cfg_q.dest_width);
      REG_DEST_HEIGHT: prdata = APB_DATA_W'(cfg_q.dest_height);
      default:         prdata = '0;
    endcase
  end

  // front: counters and classification
  ibsd_front #(
    .MAX_DEST_WIDTH (MAX_DEST_WIDTH),
    .QW             (QW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .restart_i (restart),
    .pix       (pix_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata)
  );

  // queue between front and back
  ibsd_queue #(
    .QW (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  // back: accumulation and results
  ibsd_back #(
    .MAX_DEST_WIDTH (MAX_DEST_WIDTH),
    .QW             (QW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .sum       (sum_o)
  );

endmodule

`default_nettype wire

// File: tb/tb_image_block_sum_downsample.sv
// testbench of the pixel binning block sum: directed table, then random images against a predictor
`timescale 1ns / 100ps

module tb_image_block_sum_downsample;
  import ibsd_pkg::*;

  localparam int unsigned MAX_DW       = DEF_MAX_DEST_WIDTH;
  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned DRAIN_GAP    = 16;
  localparam int unsigned CYCLE_LIMIT  = 500_000;

  // addresses past the register list, writes there must change nothing
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  localparam longint SUM_HI = $signed(SUM_MAX);
  localparam longint SUM_LO = $signed(SUM_MIN);

  typedef struct packed {
    logic signed [SUM_W-1:0] block_sum;
    logic [COL_OUT_W-1:0]    dest_col;
    logic [ROW_W-1:0]        dest_row;
    logic                    image_done;
  } bin_result_t;

  typedef enum bit {ROW_WRITE, ROW_PIXEL} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [2:0]  reg_idx;
    logic [31:0] data;
    bit          typed;
    bin_result_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  ibsd_pix_if pix_if ();
  ibsd_sum_if sum_if ();

  image_block_sum_downsample #(
    .MAX_DEST_WIDTH(MAX_DW)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .sum_o  (sum_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #10 clk_i = ~clk_i;

  // predictor state: configuration, accumulator row and raster position
  ibsd_cfg_t   bin_cfg;
  longint      acc_row [MAX_DW];
  int unsigned src_x, src_y, in_blk_x, in_blk_y, blk_x, blk_y;

  bin_result_t due_block_sums [$];
  stim_row_t   directed_rows [$];
  int          errors = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int unsigned cycle_count = 0;

  function automatic void restart_binning();
    for (int i = 0; i < MAX_DW; i++) acc_row[i] = 0;
    src_x = 0; src_y = 0;
    in_blk_x = 0; in_blk_y = 0;
    blk_x = 0; blk_y = 0;
  endfunction

  function automatic void apply_reg_write(logic [2:0] idx, logic [31:0] data);
    case (idx)
      REG_SRC_WIDTH:   bin_cfg.src_width   = data[DIM_W-1:0];
      REG_SRC_HEIGHT:  bin_cfg.src_height  = data[DIM_W-1:0];
      REG_FACTOR_X:    bin_cfg.factor_x    = data[FACT_W-1:0];
      REG_FACTOR_Y:    bin_cfg.factor_y    = data[FACT_W-1:0];
      REG_DEST_WIDTH:  bin_cfg.dest_width  = data[DWID_W-1:0];
      REG_DEST_HEIGHT: bin_cfg.dest_height = data[DIM_W-1:0];
      default:         return;
    endcase
    restart_binning();
  endfunction

  // one source pixel into the accumulator row, returns 1 when a block inside the destination completes
  function automatic bit bin_pixel(logic signed [PIX_W-1:0] pix, output bin_result_t res);
    int unsigned sw, sh, fx, fy, dw, dh;
    bit          row_end, col_end, blk_end_x, blk_end_y, in_dest;
    longint      s;
    sw = (bin_cfg.src_width == 0) ? 1 : bin_cfg.src_width;
    sh = (bin_cfg.src_height == 0) ? 1 : bin_cfg.src_height;
    fx = (bin_cfg.factor_x == 0) ? 1 : (bin_cfg.factor_x > FACT_MAX) ? FACT_MAX : bin_cfg.factor_x;
    fy = (bin_cfg.factor_y == 0) ? 1 : (bin_cfg.factor_y > FACT_MAX) ? FACT_MAX : bin_cfg.factor_y;
    dw = (bin_cfg.dest_width == 0) ? 1 : bin_cfg.dest_width;
    dh = (bin_cfg.dest_height == 0) ? 1 : bin_cfg.dest_height;
    if (dw > MAX_DW) dw = MAX_DW;
    res = '0;
    bin_pixel = 1'b0;

    row_end   = (src_x + 1 >= sw);
    col_end   = (src_y + 1 >= sh);
    blk_end_x = (in_blk_x + 1 >= fx) || row_end;
    blk_end_y = (in_blk_y + 1 >= fy) || col_end;
    in_dest   = (blk_x < dw) && (blk_y < dh);

    // saturating add into the block accumulator
    if (in_dest) begin
      s = acc_row[blk_x] + longint'(pix);
      if (s > SUM_HI) s = SUM_HI;
      if (s < SUM_LO) s = SUM_LO;
      if (blk_end_x && blk_end_y) begin
        res.block_sum  = s[SUM_W-1:0];
        res.dest_col   = blk_x[COL_OUT_W-1:0];
        res.dest_row   = blk_y[ROW_W-1:0];
        res.image_done = (row_end || blk_x + 1 >= dw) && (col_end || blk_y + 1 >= dh);
        acc_row[blk_x] = 0;
        bin_pixel = 1'b1;
      end else begin
        acc_row[blk_x] = s;
      end
    end

    // raster advance
    if (row_end) begin
      src_x = 0; in_blk_x = 0; blk_x = 0;
      if (col_end) begin
        src_y = 0; in_blk_y = 0; blk_y = 0;
      end else begin
        src_y++;
        if (in_blk_y + 1 >= fy) begin
          in_blk_y = 0;
          blk_y++;
        end else begin
          in_blk_y++;
        end
      end
    end else begin
      src_x++;
      if (in_blk_x + 1 >= fx) begin
        in_blk_x = 0;
        blk_x++;
      end else begin
        in_blk_x++;
      end
    end
  endfunction

  function automatic stim_row_t wr_row(logic [2:0] idx, logic [31:0] data);
    wr_row = '{kind: ROW_WRITE, reg_idx: idx, data: data, typed: 1'b0, want: '0};
  endfunction

  function automatic stim_row_t px_row(logic [31:0] data);
    px_row = '{kind: ROW_PIXEL, reg_idx: '0, data: data, typed: 1'b0, want: '0};
  endfunction

  function automatic stim_row_t px_typed(logic [31:0] data, logic [SUM_W-1:0] bsum,
                                         logic [COL_OUT_W-1:0] col, logic [ROW_W-1:0] row,
                                         logic done);
    px_typed = '{kind: ROW_PIXEL, reg_idx: '0, data: data, typed: 1'b1,
                 want: '{block_sum: bsum, dest_col: col, dest_row: row, image_done: done}};
  endfunction

  // register value, sometimes with junk above the register width
  function automatic logic [31:0] reg_data(int unsigned value, int unsigned width);
    logic [31:0] low_mask;
    low_mask = (32'h1 << width) - 1;
    if ($urandom_range(0, 3) == 0) reg_data = ($urandom & ~low_mask) | (value & low_mask);
    else reg_data = value & low_mask;
  endfunction

  // apb write: setup, access, then idle with psel low
  task automatic reg_write(logic [2:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    apply_reg_write(idx, data);
    @(posedge clk_i);
  endtask

  // hold the sender until every expected sum is out, optionally let the pipe settle
  task automatic wait_drained(bit settle);
    pix_if.valid <= 1'b0;
    do @(posedge clk_i); while (due_block_sums.size() != 0);
    if (settle) repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  // offer one pixel item with random gaps, predict once it is taken
  task automatic send_pixel(logic [31:0] value, bit typed, bin_result_t want);
    bin_result_t res;
    bit          hit;
    while ($urandom_range(0, 99) < idle_pct) begin
      pix_if.valid       <= 1'b0;
      pix_if.pixel_value <= $urandom;
      @(posedge clk_i);
    end
    pix_if.valid       <= 1'b1;
    pix_if.pixel_value <= value;
    do @(posedge clk_i); while (pix_if.ready !== 1'b1);
    hit = bin_pixel(value, res);
    if (typed) due_block_sums.push_back(want);
    else if (hit) due_block_sums.push_back(res);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // result side: random stalls
  initial begin
    sum_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      sum_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // compare each taken sum with the oldest prediction
  always @(posedge clk_i) begin : check_sums
    bin_result_t want;
    if (rst_ni === 1'b1 && sum_if.valid === 1'b1 && sum_if.ready === 1'b1) begin
      if (due_block_sums.size() == 0) begin
        $error("block sum item with nothing expected: col %0d row %0d sum %0h",
               sum_if.dest_col, sum_if.dest_row, sum_if.block_sum);
        errors++;
      end else begin
        want = due_block_sums.pop_front();
        check_field("block_sum", 64'(want.block_sum), 64'(sum_if.block_sum));
        check_field("dest_col", 64'(want.dest_col), 64'(sum_if.dest_col));
        check_field("dest_row", 64'(want.dest_row), 64'(sum_if.dest_row));
        check_field("image_done", 64'(want.image_done), 64'(sum_if.image_done));
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_image_block_sum_downsample: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned sw, sh, fx, fy, dw, dh, eff_w, eff_h, n_pix, shape, phase, pause_at;
    int unsigned random_items;
    logic [31:0] pix;
    bit          spare;
    stim_row_t   row;

    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    pix_if.valid       = 1'b0;
    pix_if.pixel_value = '0;
    bin_cfg            = CFG_RESET;
    restart_binning();
    random_items       = 0;

    // after reset every pixel is a whole one-pixel image
    directed_rows.push_back(px_typed(32'h7FFF_FFFF, 48'h0000_7FFF_FFFF, 0, 0, 1'b1));
    directed_rows.push_back(px_typed(32'h8000_0000, 48'hFFFF_8000_0000, 0, 0, 1'b1));
    directed_rows.push_back(px_typed(32'h0000_0000, 48'h0000_0000_0000, 0, 0, 1'b1));
    directed_rows.push_back(px_typed(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 0, 0, 1'b1));
    // 3x2 source, 2x2 blocks, partial block on the right edge
    directed_rows.push_back(wr_row(REG_SRC_WIDTH, 32'hFFFF_0003));
    directed_rows.push_back(wr_row(REG_SRC_HEIGHT, 32'd2));
    directed_rows.push_back(wr_row(REG_FACTOR_X, 32'd2));
    directed_rows.push_back(wr_row(REG_FACTOR_Y, 32'd2));
    directed_rows.push_back(wr_row(REG_DEST_WIDTH, 32'd2));
    directed_rows.push_back(wr_row(REG_DEST_HEIGHT, 32'd1));
    directed_rows.push_back(px_row(32'h7FFF_FFFF));
    directed_rows.push_back(px_row(32'h7FFF_FFFF));
    directed_rows.push_back(px_row(32'h8000_0000));
    directed_rows.push_back(px_row(32'h7FFF_FFFF));
    directed_rows.push_back(px_row(32'h7FFF_FFFF));
    directed_rows.push_back(px_row(32'h8000_0000));
    // zero factor, oversize factor, zero destination width
    directed_rows.push_back(wr_row(REG_FACTOR_X, 32'd0));
    directed_rows.push_back(wr_row(REG_FACTOR_Y, 32'd300));
    directed_rows.push_back(wr_row(REG_DEST_WIDTH, 32'd0));
    directed_rows.push_back(px_row(32'h0000_0011));
    directed_rows.push_back(px_row(32'hFFFF_FFF0));
    directed_rows.push_back(px_row(32'h1234_5678));
    // write past the register list mid-image, the image continues
    directed_rows.push_back(wr_row(REG_SPARE_LO, 32'hFFFF_FFFF));
    directed_rows.push_back(px_row(32'h0000_0005));
    directed_rows.push_back(px_row(32'h8765_4321));
    directed_rows.push_back(px_row(32'h0000_0007));
    // destination wider than the row, zero heights
    directed_rows.push_back(wr_row(REG_DEST_WIDTH, 32'd8191));
    directed_rows.push_back(wr_row(REG_SRC_WIDTH, 32'd5));
    directed_rows.push_back(wr_row(REG_FACTOR_X, 32'd1));
    directed_rows.push_back(wr_row(REG_DEST_HEIGHT, 32'd0));
    directed_rows.push_back(wr_row(REG_SRC_HEIGHT, 32'd0));
    directed_rows.push_back(px_row(32'h0000_0001));
    directed_rows.push_back(px_row(32'h7FFF_FFFF));
    directed_rows.push_back(px_row(32'h8000_0000));
    directed_rows.push_back(px_row(32'hFFFF_FFFF));
    directed_rows.push_back(px_row(32'h0000_0000));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        wait_drained(1'b1);
        reg_write(row.reg_idx, row.data);
      end else begin
        send_pixel(row.data, row.typed, row.want);
      end
    end

    // random images, one configuration per phase
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (phase % 5)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        3: begin idle_pct = 30; stall_pct = 30; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase

      sw = $urandom_range(1, 12);
      sh = $urandom_range(1, 10);
      fx = $urandom_range(1, 5);
      fy = $urandom_range(1, 4);
      dw = $urandom_range(1, (sw + fx - 1) / fx + 1);
      dh = $urandom_range(1, (sh + fy - 1) / fy + 1);
      shape = $urandom_range(0, 9);
      case (shape)
        // zero sizes and factors
        6: begin
          if ($urandom_range(0, 2) == 0) sw = 0;
          if ($urandom_range(0, 2) == 0) sh = 0;
          if ($urandom_range(0, 2) == 0) fx = 0;
          if ($urandom_range(0, 2) == 0) fy = 0;
          if ($urandom_range(0, 2) == 0) dw = 0;
          if ($urandom_range(0, 2) == 0) dh = 0;
        end
        // largest and oversize factors
        7: begin
          fx = $urandom_range(0, 1) ? FACT_MAX : $urandom_range(257, 511);
          if ($urandom_range(0, 1)) fy = $urandom_range(0, 1) ? FACT_MAX : $urandom_range(257, 511);
          sw = $urandom_range(1, 40);
          dw = $urandom_range(1, 2);
          if ($urandom_range(0, 3) == 0) begin
            sw = 258;
            sh = 1;
          end
        end
        // destination at and beyond the row length
        8: begin
          sw = $urandom_range(1, 20);
          fx = $urandom_range(1, 3);
          dw = $urandom_range(0, 1) ? MAX_DW : $urandom_range(MAX_DW + 1, 8191);
        end
        // largest source sizes, image left unfinished
        9: begin
          if ($urandom_range(0, 1)) begin
            sw = 16'hFFFF;
            sh = $urandom_range(1, 3);
          end else begin
            sh = 16'hFFFF;
            sw = $urandom_range(1, 6);
          end
          dh = $urandom_range(0, 1) ? 16'hFFFF : $urandom_range(1, 4);
        end
        default: ;
      endcase

      eff_w = (sw == 0) ? 1 : sw;
      eff_h = (sh == 0) ? 1 : sh;
      n_pix = eff_w * eff_h * $urandom_range(1, 2);
      if ($urandom_range(0, 4) == 0) n_pix = $urandom_range(1, eff_w * eff_h);
      if (n_pix > 300) n_pix = 300;
      pause_at = ($urandom_range(0, 2) == 0) ? $urandom_range(1, n_pix) : n_pix + 1;

      wait_drained(1'b1);
      reg_write(REG_SRC_WIDTH, reg_data(sw, DIM_W));
      reg_write(REG_SRC_HEIGHT, reg_data(sh, DIM_W));
      reg_write(REG_FACTOR_X, reg_data(fx, FACT_W));
      reg_write(REG_FACTOR_Y, reg_data(fy, FACT_W));
      reg_write(REG_DEST_WIDTH, reg_data(dw, DWID_W));
      reg_write(REG_DEST_HEIGHT, reg_data(dh, DIM_W));

      for (int i = 0; i < n_pix; i++) begin
        // sender holds off mid-image, sometimes with a write past the list
        if (i == pause_at) begin
          spare = $urandom_range(0, 1);
          wait_drained(spare);
          if (spare) reg_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
        end
        case ($urandom_range(0, 15))
          0:       pix = 32'h7FFF_FFFF;
          1:       pix = 32'h8000_0000;
          2:       pix = 32'h0000_0000;
          3:       pix = 32'hFFFF_FFFF;
          default: pix = $urandom;
        endcase
        send_pixel(pix, 1'b0, '0);
        random_items++;
      end
      phase++;
    end

    wait_drained(1'b1);
    if (errors == 0) begin
      $display("tb_image_block_sum_downsample: PASS");
    end else begin
      $display("tb_image_block_sum_downsample: FAIL");
    end
    $finish;
  end

endmodule
